// ----- hw/rtl/size_class_bitmap_slab_allocator_core_assert.svh -----
// Assertion macros for the slab allocator core.
`ifndef SIZE_CLASS_BITMAP_SLAB_ALLOCATOR_CORE_ASSERT_SVH
`define SIZE_CLASS_BITMAP_SLAB_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SCA_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define SCA_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define SCA_ASSERT_IMP(label, clk, rst, a, c, msg)
`define SCA_ASSERT_NXT(label, clk, rst, a, c, msg)
`endif
`endif

// ----- hw/rtl/sca_pkg.sv -----
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types and constants of the slab allocator core.
// ----------------------------------------------------------------------------
package sca_pkg;
  localparam int NumPages = 16;
  localparam int PageW = $clog2(NumPages);
  localparam int LinkW = PageW + 1;
  localparam logic [LinkW-1:0] NullLink = LinkW'(NumPages);
  localparam int BitmapWords = 7;
  localparam int WordW = 3;
  localparam int SizeClasses = 7;
  localparam int ClassW = 3;
  localparam int SlotW = 9;
  localparam int CountW = 9;
  localparam int BmDepth = NumPages * BitmapWords;
  localparam int BmAddrW = $clog2(BmDepth);

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_TOO_LARGE = 2'd1, ST_NO_PAGE = 2'd2, ST_BAD_FREE = 2'd3
  } status_t;

  typedef enum logic {OP_ALLOC = 1'b0, OP_FREE = 1'b1} op_t;

  // Classified command handed from front to back.
  typedef struct packed {
    logic              is_free;
    logic              bad;      // early error, status in code
    status_t           code;
    logic [ClassW-1:0] cls;
    logic [15:0]       addr;
  } cmd_t;

  // Capacity in slots of a class: 3584 >> (cls + 3).
  function automatic logic [CountW:0] class_cap(input logic [ClassW-1:0] c);
    logic [12:0] d;
    d = 13'd3584 >> ({1'b0, c} + 4'd3);
    return d[CountW:0];
  endfunction
endpackage

// ----- hw/rtl/sca_front.sv -----
// ----------------------------------------------------------------------------
// sca_front
// Accepts commands, rounds sizes to a class and screens oversize requests.
// ----------------------------------------------------------------------------
module sca_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic [11:0]        request_size,
  input  logic [15:0]        free_address,
  output logic               cmd_valid,
  output sca_pkg::cmd_t      cmd,
  input  logic               cmd_take
);
  // two-entry queue
  sca_pkg::cmd_t q [2];
  logic [1:0] cnt;
  logic       rd, wr;
  logic       inflight;
  sca_pkg::cmd_t c_in;
  logic [2:0] shift;

  always_comb begin
    shift = 3'd3;
    for (int s = 4; s <= 9; s++) begin
      if (request_size > 12'((1 << (s - 1)))) shift = 3'(s);
    end
    c_in.is_free = (operation == sca_pkg::OP_FREE);
    c_in.addr = free_address;
    c_in.cls = shift - 3'd3;
    c_in.bad = (operation == sca_pkg::OP_ALLOC) && (request_size > 12'd512);
    c_in.code = sca_pkg::ST_TOO_LARGE;
  end

  // Hold at most one command in the queue; the back end drains it in order.
  assign busy = (cnt != 2'd0) || inflight;
  assign wr = start && !busy;
  assign rd = cmd_valid && cmd_take;
  assign cmd_valid = cnt != 2'd0;
  assign cmd = q[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      inflight <= 1'b0;
    end else begin
      cnt <= cnt + 2'(wr) - 2'(rd);
      if (wr) inflight <= 1'b1;
      else if (rd) inflight <= 1'b0;
    end
    if (rd) q[0] <= q[1];
    if (wr) begin
      if (cnt == 2'd0 || (cnt == 2'd1 && rd)) q[0] <= c_in;
      else q[1] <= c_in;
    end
  end
endmodule

// ----- hw/rtl/sca_back.sv -----
// ----------------------------------------------------------------------------
// sca_back
// Executes commands: walks class lists, scans bitmap words, updates pages.
// ----------------------------------------------------------------------------
`include "size_class_bitmap_slab_allocator_core_assert.svh"
module sca_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  sca_pkg::cmd_t      cmd,
  output logic               cmd_take,
  output logic               done,
  output logic [1:0]         status,
  output logic [15:0]        piece_address,
  output logic               page_released
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PAGE  = 10'b0000000010,
    S_WRD   = 10'b0000000100,
    S_WCHK  = 10'b0000001000,
    S_CLAIM = 10'b0000010000,
    S_CLR   = 10'b0000100000,
    S_FRD   = 10'b0001000000,
    S_FCHK  = 10'b0010000000,
    S_UNL   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;
  state_t st;

  logic [63:0] bm_mem [sca_pkg::BmDepth];
  logic [sca_pkg::BmAddrW-1:0] bm_ra, bm_wa;
  logic [63:0] bm_rd, bm_wd;
  logic bm_we;
  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_wa] <= bm_wd;
    bm_rd <= bm_mem[bm_ra];
  end

  logic [sca_pkg::NumPages-1:0] in_use;
  logic [sca_pkg::ClassW-1:0] pcls [sca_pkg::NumPages];
  logic [sca_pkg::CountW-1:0] pcnt [sca_pkg::NumPages];
  logic [sca_pkg::LinkW-1:0]  plink [sca_pkg::NumPages];
  logic [sca_pkg::LinkW-1:0]  head [sca_pkg::SizeClasses];

  sca_pkg::cmd_t c;
  logic [sca_pkg::LinkW-1:0] cur, prev;
  logic [sca_pkg::WordW-1:0] wd;
  logic [4:0] steps;
  logic [sca_pkg::SlotW-1:0] slot;
  logic [sca_pkg::PageW-1:0] fpg;
  logic [1:0] r_status;
  logic [15:0] r_addr;
  logic r_rel;

  logic [sca_pkg::PageW-1:0] cpg;
  assign cpg = cur[sca_pkg::PageW-1:0];
  logic [sca_pkg::CountW:0] cap;
  assign cap = sca_pkg::class_cap(c.cls);

  // lowest clear bit of the read word
  logic [5:0] lz;
  logic lz_any;
  always_comb begin
    lz = 6'd0;
    lz_any = 1'b0;
    for (int b = 63; b >= 0; b--) begin
      if (!bm_rd[b]) begin
        lz = 6'(b);
        lz_any = 1'b1;
      end
    end
  end

  logic [sca_pkg::PageW-1:0] freep;
  logic free_any;
  always_comb begin
    freep = '0;
    free_any = 1'b0;
    for (int p = sca_pkg::NumPages - 1; p >= 0; p--) begin
      if (!in_use[p]) begin
        freep = sca_pkg::PageW'(p);
        free_any = 1'b1;
      end
    end
  end

  // free address decode
  logic [3:0] f_pg;
  logic [11:0] f_off, f_rel;
  logic [2:0] f_cls;
  logic [3:0] f_sh;
  logic f_ok;
  logic [sca_pkg::SlotW-1:0] f_slot;
  always_comb begin
    f_pg = c.addr[15:12];
    f_off = c.addr[11:0];
    f_rel = f_off - 12'd512;
    f_cls = pcls[f_pg[sca_pkg::PageW-1:0]];
    f_sh = {1'b0, f_cls} + 4'd3;
    f_slot = sca_pkg::SlotW'(f_rel >> f_sh);
    f_ok = in_use[f_pg[sca_pkg::PageW-1:0]] && (f_off >= 12'd512)
        && ((f_rel & ((12'd1 << f_sh) - 12'd1)) == 12'd0)
        && (f_slot[8:6] < 3'(sca_pkg::BitmapWords));
  end

  logic [15:0] addr_calc;
  logic [sca_pkg::SlotW-1:0] take_slot;
  assign take_slot = {wd, lz};
  assign addr_calc = {cpg, 12'd512} + (16'(take_slot) << ({1'b0, c.cls} + 4'd3));

  assign cmd_take = (st == S_IDLE) && cmd_valid;

  always_comb begin
    bm_ra = sca_pkg::BmAddrW'(cpg * sca_pkg::BitmapWords + wd);
    bm_we = 1'b0;
    bm_wa = bm_ra;
    bm_wd = bm_rd | (64'd1 << lz);
    case (st)
      S_WCHK: bm_we = lz_any && (take_slot < cap[sca_pkg::SlotW-1:0] || cap > 10'd511);
      S_CLR: begin
        bm_we = 1'b1;
        bm_wa = sca_pkg::BmAddrW'(fpg * sca_pkg::BitmapWords + wd);
        bm_wd = (wd == 3'd0) ? 64'd1 : 64'd0;
      end
      // address the slot word straight from the decode so it is ready in S_FCHK
      S_FRD: begin
        bm_ra = sca_pkg::BmAddrW'(f_pg[sca_pkg::PageW-1:0] * sca_pkg::BitmapWords
                                  + f_slot[8:6]);
        bm_wa = bm_ra;
      end
      S_FCHK: begin
        bm_ra = sca_pkg::BmAddrW'(fpg * sca_pkg::BitmapWords + slot[8:6]);
        bm_wa = bm_ra;
        bm_wd = bm_rd & ~(64'd1 << slot[5:0]);
        bm_we = bm_rd[slot[5:0]];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      in_use <= '0;
      for (int i = 0; i < sca_pkg::SizeClasses; i++) head[i] <= sca_pkg::NullLink;
    end else begin
      case (st)
        S_IDLE: if (cmd_valid) begin
          c <= cmd;
          r_status <= cmd.bad ? cmd.code : sca_pkg::ST_OK;
          r_addr <= 16'd0;
          r_rel <= 1'b0;
          steps <= '0;
          prev <= sca_pkg::NullLink;
          cur <= head[cmd.cls];
          wd <= '0;
          if (cmd.bad) st <= S_DONE;
          else if (cmd.is_free) st <= S_FRD;
          else st <= S_PAGE;
        end
        S_PAGE: begin
          wd <= '0;
          if (cur == sca_pkg::NullLink || steps == 5'(sca_pkg::NumPages)) st <= S_CLAIM;
          else if ({1'b0, pcnt[cpg]} < cap) st <= S_WRD;
          else begin
            prev <= cur;
            cur <= plink[cpg];
            steps <= steps + 5'd1;
          end
        end
        S_WRD: st <= S_WCHK;
        S_WCHK: begin
          if (lz_any && {1'b0, take_slot} < cap) begin
            pcnt[cpg] <= pcnt[cpg] + 9'd1;
            r_addr <= addr_calc;
            st <= S_DONE;
          end else if (lz_any || wd == 3'(sca_pkg::BitmapWords - 1)) begin
            prev <= cur;
            cur <= plink[cpg];
            steps <= steps + 5'd1;
            st <= S_PAGE;
          end else begin
            wd <= wd + 3'd1;
            st <= S_WRD;
          end
        end
        S_CLAIM: begin
          if (!free_any) begin
            r_status <= sca_pkg::ST_NO_PAGE;
            st <= S_DONE;
          end else begin
            fpg <= freep;
            in_use[freep] <= 1'b1;
            pcls[freep] <= c.cls;
            pcnt[freep] <= 9'd1;
            plink[freep] <= sca_pkg::NullLink;
            if (prev == sca_pkg::NullLink) head[c.cls] <= {1'b0, freep};
            else plink[prev[sca_pkg::PageW-1:0]] <= {1'b0, freep};
            r_addr <= {freep, 12'd512};
            wd <= '0;
            st <= S_CLR;
          end
        end
        S_CLR: begin
          wd <= wd + 3'd1;
          if (wd == 3'(sca_pkg::BitmapWords - 1)) st <= S_DONE;
        end
        S_FRD: begin
          if (!f_ok) begin
            r_status <= sca_pkg::ST_BAD_FREE;
            st <= S_DONE;
          end else begin
            fpg <= f_pg[sca_pkg::PageW-1:0];
            slot <= f_slot;
            c.cls <= f_cls;
            st <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (!bm_rd[slot[5:0]]) begin
            r_status <= sca_pkg::ST_BAD_FREE;
            st <= S_DONE;
          end else if (pcnt[fpg] > 9'd1) begin
            pcnt[fpg] <= pcnt[fpg] - 9'd1;
            st <= S_DONE;
          end else begin
            pcnt[fpg] <= 9'd0;
            cur <= head[c.cls];
            prev <= sca_pkg::NullLink;
            steps <= '0;
            st <= S_UNL;
          end
        end
        S_UNL: begin
          if (cur == sca_pkg::NullLink || steps == 5'(sca_pkg::NumPages)) begin
            in_use[fpg] <= 1'b0;
            plink[fpg] <= sca_pkg::NullLink;
            r_rel <= 1'b1;
            st <= S_DONE;
          end else if (cpg == fpg) begin
            if (prev == sca_pkg::NullLink) head[c.cls] <= plink[fpg];
            else plink[prev[sca_pkg::PageW-1:0]] <= plink[fpg];
            steps <= 5'(sca_pkg::NumPages);
          end else begin
            prev <= cur;
            cur <= plink[cpg];
            steps <= steps + 5'd1;
          end
        end
        S_DONE: st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  assign done = (st == S_DONE);
  assign status = r_status;
  assign piece_address = r_addr;
  assign page_released = r_rel;

  `SCA_ASSERT_IMP(a_onehot, clk, rst, 1'b1, $onehot(st), "state not one-hot")
  `SCA_ASSERT_IMP(a_err_addr, clk, rst, done && r_status != sca_pkg::ST_OK, r_addr == 16'd0, "error with address")
  `SCA_ASSERT_NXT(a_done_idle, clk, rst, done, st == S_IDLE, "done not followed by idle")
endmodule

// ----- hw/rtl/size_class_bitmap_slab_allocator_core.sv -----
// ----------------------------------------------------------------------------
// size_class_bitmap_slab_allocator_core
// Power-of-two size-class slab allocator over 16 pages with slot bitmaps.
// ----------------------------------------------------------------------------
// Usage: raise start with operation, request_size and free_address while busy
// is low; that edge transfers the command. Exactly one result follows, shown
// for one cycle with done high on status, piece_address and page_released.
// The receiver cannot stall; the result must be taken in that cycle.
// An oversize request or a bad free goes straight to the result, and a free
// that keeps its page only lowers its count; a free that releases its page
// first walks the class list to unlink it. An allocate walks the class list
// past full pages and scans bitmap words one at a time (one memory read
// port); claiming a new page clears its bitmap words before the result.
// busy is high only while a command waits in the front queue; one more
// command can be transferred while the back end works on the previous one.
// Reset (synchronous rst) empties all class lists and the page pool.
// ----------------------------------------------------------------------------
module size_class_bitmap_slab_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [11:0] request_size,
  input  logic [15:0] free_address,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] piece_address,
  output logic        page_released
);
  logic cmd_valid, cmd_take;
  sca_pkg::cmd_t cmd;

  sca_front u_front (
    .clk, .rst, .start, .busy, .operation, .request_size, .free_address,
    .cmd_valid, .cmd, .cmd_take
  );

  sca_back u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take, .done, .status, .piece_address,
    .page_released
  );
endmodule
